// ===== src/assert_macros.svh =====
// assert_macros.svh: assertion macros shared by the prime test/next-prime RTL.
// Expects clk and rst_n (synchronous, active low) in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_AT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Expression is never true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// ===== src/ptn_pkg.sv =====
// ptn_pkg: types, widths and microcode field codes for the prime test/next-prime block.
// Used by ptn_div, ptn_dp, ptn_seq and prime_test_and_next_top.
package ptn_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam int unsigned AW    = 6;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [WIDTH:0]   wide_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [AW-1:0]    addr_t;

  typedef struct packed {
    logic        func;
    logic [31:0] number;
  } in_t;

  typedef struct packed {
    logic        is_prime;
    logic [31:0] prime_value;
    logic        overflow;
  } out_t;

  // step wait reasons
  typedef enum logic [1:0] {W_NONE, W_IN, W_DIV, W_OUT} wait_t;

  // jump conditions
  typedef enum logic [3:0] {
    COND_NEVER, COND_ALWAYS, COND_FUNC, COND_C_LT2, COND_C_LT4, COND_N_LT2,
    COND_N_EQ2, COND_N_MAX, COND_C_MAX, COND_M_OK, COND_STEP_OVF,
    COND_REM_ZERO, COND_Q_LT_D
  } cond_t;

  typedef enum logic [2:0] {C_HOLD, C_LOAD_N, C_LOAD_INC, C_INC, C_STEP} c_op_t;
  typedef enum logic [2:0] {D_HOLD, D_2, D_3, D_5, D_6, D_ADD2, D_ADD4} d_op_t;
  typedef enum logic [1:0] {M_HOLD, M_REM, M_INC, M_STEP} m_op_t;
  typedef enum logic [2:0] {
    E_NONE, E_TEST_T, E_TEST_F, E_NEXT_C, E_NEXT_2, E_NEXT_3, E_OVF
  } emit_t;

  typedef struct packed {
    wait_t wt;
    cond_t cond;
    addr_t target;
    c_op_t c_op;
    d_op_t d_op;
    m_op_t m_op;
    logic  div_start;
    emit_t emit;
  } ctl_t;

  typedef struct packed {
    logic accept;
    logic div_busy;
    logic out_busy;
    logic func;
    logic c_lt2;
    logic c_lt4;
    logic n_lt2;
    logic n_eq2;
    logic n_max;
    logic c_max;
    logic m_ok;
    logic step_ovf;
    logic rem_zero;
    logic q_lt_d;
  } stat_t;

endpackage

// ===== src/ptn_div.sv =====
// ptn_div: restoring divider, one quotient bit per cycle.
// Depends on ptn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptn_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  ptn_pkg::word_t dividend,
  input  ptn_pkg::word_t divisor,
  output logic          busy,
  output ptn_pkg::word_t quotient,
  output ptn_pkg::word_t remainder
);

  logic           busy_r, busy_nxt;
  ptn_pkg::cnt_t  cnt_r, cnt_nxt;
  ptn_pkg::word_t quo_r, rem_r, den_r;
  ptn_pkg::wide_t shifted, diff;
  logic           ge;

  assign shifted = {rem_r, quo_r[ptn_pkg::WIDTH-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = (shifted >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ptn_pkg::cnt_t'(ptn_pkg::WIDTH - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - ptn_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[ptn_pkg::WIDTH-2:0], ge};
      rem_r <= ge ? diff[ptn_pkg::WIDTH-1:0] : shifted[ptn_pkg::WIDTH-1:0];
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  `ASSERT_NEVER(a_no_restart, start && busy_r, "divide started while busy")
  `ASSERT_AT_CLK(a_full_run, $fell(busy_r) |-> ($past(cnt_r) == '0), "divide ended early")

endmodule

// ===== src/ptn_dp.sv =====
// ptn_dp: operand, candidate, divisor and residue registers driven by the control word.
// Depends on ptn_pkg and instantiates ptn_div.
module ptn_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  ptn_pkg::in_t   in_data,
  input  ptn_pkg::ctl_t  ctl,
  input  logic           out_busy,
  output ptn_pkg::stat_t stat,
  output ptn_pkg::word_t n_val,
  output ptn_pkg::word_t c_val
);

  logic           func_r;
  ptn_pkg::word_t n_r, c_r, d_r, c_nxt, d_nxt;
  logic [2:0]     m_r, m_nxt, step_val;
  ptn_pkg::wide_t step_sum;
  logic           div_busy;
  ptn_pkg::word_t quo, rem;

  ptn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ctl.div_start),
    .dividend  (c_r),
    .divisor   (d_r),
    .busy      (div_busy),
    .quotient  (quo),
    .remainder (rem)
  );

  // 6k+1 advances by 4, 6k-1 by 2
  assign step_val = (m_r == 3'd1) ? 3'd4 : 3'd2;
  assign step_sum = {1'b0, c_r} + ptn_pkg::wide_t'(step_val);

  always_comb begin
    unique case (ctl.c_op)
      ptn_pkg::C_HOLD:     c_nxt = c_r;
      ptn_pkg::C_LOAD_N:   c_nxt = n_r;
      ptn_pkg::C_LOAD_INC: c_nxt = n_r + ptn_pkg::word_t'(1);
      ptn_pkg::C_INC:      c_nxt = c_r + ptn_pkg::word_t'(1);
      ptn_pkg::C_STEP:     c_nxt = step_sum[ptn_pkg::WIDTH-1:0];
      default:             c_nxt = c_r;
    endcase
    unique case (ctl.d_op)
      ptn_pkg::D_HOLD: d_nxt = d_r;
      ptn_pkg::D_2:    d_nxt = ptn_pkg::word_t'(2);
      ptn_pkg::D_3:    d_nxt = ptn_pkg::word_t'(3);
      ptn_pkg::D_5:    d_nxt = ptn_pkg::word_t'(5);
      ptn_pkg::D_6:    d_nxt = ptn_pkg::word_t'(6);
      ptn_pkg::D_ADD2: d_nxt = d_r + ptn_pkg::word_t'(2);
      ptn_pkg::D_ADD4: d_nxt = d_r + ptn_pkg::word_t'(4);
      default:         d_nxt = d_r;
    endcase
    unique case (ctl.m_op)
      ptn_pkg::M_HOLD: m_nxt = m_r;
      ptn_pkg::M_REM:  m_nxt = rem[2:0];
      ptn_pkg::M_INC:  m_nxt = (m_r == 3'd5) ? 3'd0 : m_r + 3'd1;
      ptn_pkg::M_STEP: m_nxt = (m_r == 3'd1) ? 3'd5 : 3'd1;
      default:         m_nxt = m_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_data.func;
      n_r    <= ptn_pkg::word_t'(in_data.number);
    end
    c_r <= c_nxt;
    d_r <= d_nxt;
    m_r <= m_nxt;
  end

  always_comb begin
    stat.accept   = accept;
    stat.div_busy = div_busy;
    stat.out_busy = out_busy;
    stat.func     = func_r;
    stat.c_lt2    = (c_r < ptn_pkg::word_t'(2));
    stat.c_lt4    = (c_r < ptn_pkg::word_t'(4));
    stat.n_lt2    = (n_r < ptn_pkg::word_t'(2));
    stat.n_eq2    = (n_r == ptn_pkg::word_t'(2));
    stat.n_max    = &n_r;
    stat.c_max    = &c_r;
    stat.m_ok     = (m_r == 3'd1) || (m_r == 3'd5);
    stat.step_ovf = step_sum[ptn_pkg::WIDTH];
    stat.rem_zero = (rem == '0);
    stat.q_lt_d   = (quo < d_r);
  end

  assign n_val = n_r;
  assign c_val = c_r;

endmodule

// ===== src/ptn_seq.sv =====
// ptn_seq: step counter and microcode ROM; issues one control word per step.
// Depends on ptn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptn_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  ptn_pkg::stat_t stat,
  output ptn_pkg::ctl_t  ctl,
  output logic           idle
);

  localparam ptn_pkg::addr_t A_IDLE  = 6'd0;
  localparam ptn_pkg::addr_t A_DISP  = 6'd1;
  localparam ptn_pkg::addr_t A_TEST  = 6'd2;
  localparam ptn_pkg::addr_t A_LOOP  = 6'd8;
  localparam ptn_pkg::addr_t A_PRIME = 6'd14;
  localparam ptn_pkg::addr_t A_COMP  = 6'd16;
  localparam ptn_pkg::addr_t A_FOUND = 6'd18;
  localparam ptn_pkg::addr_t A_NEXT  = 6'd19;
  localparam ptn_pkg::addr_t A_ALIGN = 6'd25;
  localparam ptn_pkg::addr_t A_STEP  = 6'd28;
  localparam ptn_pkg::addr_t A_EMIT2 = 6'd30;
  localparam ptn_pkg::addr_t A_EMIT3 = 6'd31;
  localparam ptn_pkg::addr_t A_OVF   = 6'd32;
  localparam ptn_pkg::addr_t A_LAST  = A_OVF;

  function automatic ptn_pkg::ctl_t rom(input ptn_pkg::addr_t a);
    ptn_pkg::ctl_t w;
    w.wt        = ptn_pkg::W_NONE;
    w.cond      = ptn_pkg::COND_NEVER;
    w.target    = A_IDLE;
    w.c_op      = ptn_pkg::C_HOLD;
    w.d_op      = ptn_pkg::D_HOLD;
    w.m_op      = ptn_pkg::M_HOLD;
    w.div_start = 1'b0;
    w.emit      = ptn_pkg::E_NONE;
    unique case (a)
      6'd0: w.wt = ptn_pkg::W_IN;
      6'd1: begin
        w.cond = ptn_pkg::COND_FUNC; w.target = A_NEXT;
        w.c_op = ptn_pkg::C_LOAD_N;  w.d_op   = ptn_pkg::D_2;
      end
      // trial division of the candidate
      6'd2: begin w.cond = ptn_pkg::COND_C_LT2; w.target = A_COMP; end
      6'd3: begin w.cond = ptn_pkg::COND_C_LT4; w.target = A_PRIME; end
      6'd4: w.div_start = 1'b1;
      6'd5: begin
        w.wt = ptn_pkg::W_DIV; w.cond = ptn_pkg::COND_REM_ZERO; w.target = A_COMP;
        w.d_op = ptn_pkg::D_3;
      end
      6'd6: w.div_start = 1'b1;
      6'd7: begin
        w.wt = ptn_pkg::W_DIV; w.cond = ptn_pkg::COND_REM_ZERO; w.target = A_COMP;
        w.d_op = ptn_pkg::D_5;
      end
      6'd8: w.div_start = 1'b1;
      // divisor above the square root: no factor left
      6'd9: begin
        w.wt = ptn_pkg::W_DIV; w.cond = ptn_pkg::COND_Q_LT_D; w.target = A_PRIME;
      end
      6'd10: begin
        w.cond = ptn_pkg::COND_REM_ZERO; w.target = A_COMP; w.d_op = ptn_pkg::D_ADD2;
      end
      6'd11: w.div_start = 1'b1;
      6'd12: begin
        w.wt = ptn_pkg::W_DIV; w.cond = ptn_pkg::COND_REM_ZERO; w.target = A_COMP;
        w.d_op = ptn_pkg::D_ADD4;
      end
      6'd13: begin w.cond = ptn_pkg::COND_ALWAYS; w.target = A_LOOP; end
      6'd14: begin w.cond = ptn_pkg::COND_FUNC; w.target = A_FOUND; end
      6'd15: begin
        w.wt = ptn_pkg::W_OUT; w.emit = ptn_pkg::E_TEST_T;
        w.cond = ptn_pkg::COND_ALWAYS; w.target = A_IDLE;
      end
      6'd16: begin w.cond = ptn_pkg::COND_FUNC; w.target = A_STEP; end
      6'd17: begin
        w.wt = ptn_pkg::W_OUT; w.emit = ptn_pkg::E_TEST_F;
        w.cond = ptn_pkg::COND_ALWAYS; w.target = A_IDLE;
      end
      6'd18: begin
        w.wt = ptn_pkg::W_OUT; w.emit = ptn_pkg::E_NEXT_C;
        w.cond = ptn_pkg::COND_ALWAYS; w.target = A_IDLE;
      end
      // next prime: small operands and top of range first
      6'd19: begin w.cond = ptn_pkg::COND_N_LT2; w.target = A_EMIT2; end
      6'd20: begin w.cond = ptn_pkg::COND_N_EQ2; w.target = A_EMIT3; end
      6'd21: begin w.cond = ptn_pkg::COND_N_MAX; w.target = A_OVF; end
      6'd22: begin w.c_op = ptn_pkg::C_LOAD_INC; w.d_op = ptn_pkg::D_6; end
      6'd23: w.div_start = 1'b1;
      6'd24: begin w.wt = ptn_pkg::W_DIV; w.m_op = ptn_pkg::M_REM; end
      // advance to the first 6k+-1 candidate
      6'd25: begin
        w.cond = ptn_pkg::COND_M_OK; w.target = A_TEST; w.d_op = ptn_pkg::D_2;
      end
      6'd26: begin w.cond = ptn_pkg::COND_C_MAX; w.target = A_OVF; end
      6'd27: begin
        w.c_op = ptn_pkg::C_INC; w.m_op = ptn_pkg::M_INC;
        w.cond = ptn_pkg::COND_ALWAYS; w.target = A_ALIGN;
      end
      6'd28: begin w.cond = ptn_pkg::COND_STEP_OVF; w.target = A_OVF; end
      6'd29: begin
        w.c_op = ptn_pkg::C_STEP; w.m_op = ptn_pkg::M_STEP; w.d_op = ptn_pkg::D_2;
        w.cond = ptn_pkg::COND_ALWAYS; w.target = A_TEST;
      end
      6'd30: begin
        w.wt = ptn_pkg::W_OUT; w.emit = ptn_pkg::E_NEXT_2;
        w.cond = ptn_pkg::COND_ALWAYS; w.target = A_IDLE;
      end
      6'd31: begin
        w.wt = ptn_pkg::W_OUT; w.emit = ptn_pkg::E_NEXT_3;
        w.cond = ptn_pkg::COND_ALWAYS; w.target = A_IDLE;
      end
      6'd32: begin
        w.wt = ptn_pkg::W_OUT; w.emit = ptn_pkg::E_OVF;
        w.cond = ptn_pkg::COND_ALWAYS; w.target = A_IDLE;
      end
      default: begin w.cond = ptn_pkg::COND_ALWAYS; w.target = A_IDLE; end
    endcase
    return w;
  endfunction

  ptn_pkg::addr_t pc_r, pc_nxt;
  ptn_pkg::ctl_t  word;
  logic           hold, taken;

  assign word = rom(pc_r);

  always_comb begin
    unique case (word.wt)
      ptn_pkg::W_NONE: hold = 1'b0;
      ptn_pkg::W_IN:   hold = !stat.accept;
      ptn_pkg::W_DIV:  hold = stat.div_busy;
      ptn_pkg::W_OUT:  hold = stat.out_busy;
      default:         hold = 1'b0;
    endcase
    unique case (word.cond)
      ptn_pkg::COND_NEVER:    taken = 1'b0;
      ptn_pkg::COND_ALWAYS:   taken = 1'b1;
      ptn_pkg::COND_FUNC:     taken = stat.func;
      ptn_pkg::COND_C_LT2:    taken = stat.c_lt2;
      ptn_pkg::COND_C_LT4:    taken = stat.c_lt4;
      ptn_pkg::COND_N_LT2:    taken = stat.n_lt2;
      ptn_pkg::COND_N_EQ2:    taken = stat.n_eq2;
      ptn_pkg::COND_N_MAX:    taken = stat.n_max;
      ptn_pkg::COND_C_MAX:    taken = stat.c_max;
      ptn_pkg::COND_M_OK:     taken = stat.m_ok;
      ptn_pkg::COND_STEP_OVF: taken = stat.step_ovf;
      ptn_pkg::COND_REM_ZERO: taken = stat.rem_zero;
      ptn_pkg::COND_Q_LT_D:   taken = stat.q_lt_d;
      default:                taken = 1'b0;
    endcase
  end

  always_comb begin
    ctl = word;
    if (hold) begin
      // drop register actions while the step waits
      ctl.c_op      = ptn_pkg::C_HOLD;
      ctl.d_op      = ptn_pkg::D_HOLD;
      ctl.m_op      = ptn_pkg::M_HOLD;
      ctl.div_start = 1'b0;
      ctl.emit      = ptn_pkg::E_NONE;
      pc_nxt        = pc_r;
    end else if (taken) begin
      pc_nxt = word.target;
    end else begin
      pc_nxt = pc_r + ptn_pkg::addr_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= A_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign idle = (pc_r == A_IDLE);

  `ASSERT_AT_CLK(a_pc_range, pc_r <= A_LAST, "step counter outside program")

endmodule

// ===== src/prime_test_and_next_top.sv =====
// Channel  Dir  Payload            Handshake
// in       in   ptn_pkg::in_t      in_valid / in_stall
// out      out  ptn_pkg::out_t     out_valid / out_stall
//
// One transaction at a time. Each trial division runs in the shared restoring divider.
// A next-prime search above 2 first steps to its first 6k+-1 candidate, then repeats
// the test for each composite candidate.
// Synchronous active-low reset returns the sequencer to idle and empties the output
// register. in_stall is high from acceptance until the result is written; out_stall
// holds the result and, when it must write a new one, the sequencer.
// Depends on ptn_pkg, ptn_seq, ptn_dp (with ptn_div) and assert_macros.svh.
`include "assert_macros.svh"

module prime_test_and_next_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ptn_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ptn_pkg::out_t out_data
);

  ptn_pkg::ctl_t  ctl;
  ptn_pkg::stat_t stat;
  ptn_pkg::word_t n_val, c_val;
  ptn_pkg::out_t  out_data_r, out_data_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           idle, accept, out_busy, load;

  assign in_stall = !idle;
  assign accept   = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;
  assign load     = (ctl.emit != ptn_pkg::E_NONE);

  ptn_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl),
    .idle  (idle)
  );

  ptn_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .ctl      (ctl),
    .out_busy (out_busy),
    .stat     (stat),
    .n_val    (n_val),
    .c_val    (c_val)
  );

  always_comb begin
    out_data_nxt = out_data_r;
    unique case (ctl.emit)
      ptn_pkg::E_NONE: out_data_nxt = out_data_r;
      ptn_pkg::E_TEST_T: begin
        out_data_nxt.is_prime    = 1'b1;
        out_data_nxt.prime_value = 32'(n_val);
        out_data_nxt.overflow    = 1'b0;
      end
      ptn_pkg::E_TEST_F: begin
        out_data_nxt.is_prime    = 1'b0;
        out_data_nxt.prime_value = 32'(n_val);
        out_data_nxt.overflow    = 1'b0;
      end
      ptn_pkg::E_NEXT_C: begin
        out_data_nxt.is_prime    = 1'b1;
        out_data_nxt.prime_value = 32'(c_val);
        out_data_nxt.overflow    = 1'b0;
      end
      ptn_pkg::E_NEXT_2: begin
        out_data_nxt.is_prime    = 1'b1;
        out_data_nxt.prime_value = 32'd2;
        out_data_nxt.overflow    = 1'b0;
      end
      ptn_pkg::E_NEXT_3: begin
        out_data_nxt.is_prime    = 1'b1;
        out_data_nxt.prime_value = 32'd3;
        out_data_nxt.overflow    = 1'b0;
      end
      ptn_pkg::E_OVF: begin
        out_data_nxt.is_prime    = 1'b0;
        out_data_nxt.prime_value = 32'd0;
        out_data_nxt.overflow    = 1'b1;
      end
      default: out_data_nxt = out_data_r;
    endcase
    out_valid_nxt = load || out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEVER(a_no_overwrite, load && out_busy, "result written over a waiting one")
  `ASSERT_AT_CLK(a_busy_after_accept, accept |=> in_stall, "input open after acceptance")

endmodule

// ===== tb/prime_test_and_next_top_tb.sv =====
// prime_test_and_next_top_tb: self-checking bench for the primality test / next-prime block.
// Checks a directed table of typed and predicted results, and random numbers through a trial-division predictor.
// Depends on ptn_pkg and prime_test_and_next_top.
module prime_test_and_next_top_tb;

  localparam logic FUNC_TEST = 1'b0;
  localparam logic FUNC_NEXT = 1'b1;
  localparam logic TYPED     = 1'b1;
  localparam logic PREDICT   = 1'b0;

  localparam int          DIRECTED_ROWS = 25;
  localparam int          RANDOM_ITEMS  = 75;
  localparam int unsigned HOLD_CYCLES   = 2000;
  localparam int unsigned CYCLE_LIMIT   = 6_000_000;

  typedef struct packed {
    logic        func;
    logic [31:0] number;
    logic        typed;
    logic        is_prime;
    logic [31:0] prime_value;
    logic        overflow;
  } row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  ptn_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  ptn_pkg::out_t out_data;

  ptn_pkg::out_t prime_results_q[$];
  ptn_pkg::out_t want_result;
  row_t          directed_rows[DIRECTED_ROWS];
  int unsigned   offered_count = 0;
  int unsigned   results_seen = 0;
  int unsigned   fail_count = 0;
  int unsigned   hold_left = 0;
  bit            hold_done = 1'b0;
  int unsigned   cycle_count = 0;

  prime_test_and_next_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit prime_by_division(longint unsigned n);
    longint unsigned d;
    if (n < 2) return 1'b0;
    if (n < 4) return 1'b1;
    if ((n & 1) == 0 || n % 3 == 0) return 1'b0;
    for (d = 5; d <= n / d; d += 6) begin
      if (n % d == 0 || n % (d + 2) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic ptn_pkg::out_t predict_result(ptn_pkg::in_t item);
    longint unsigned top_val;
    longint unsigned n;
    longint unsigned cand;
    longint unsigned step;
    bit              ovf;
    ptn_pkg::out_t   res;
    top_val = (ptn_pkg::WIDTH >= 64) ? '1 : ((64'd1 << ptn_pkg::WIDTH) - 1);
    n = longint'(item.number) & top_val;
    res = '0;
    ovf = 1'b0;
    if (item.func == FUNC_TEST) begin
      res.is_prime = prime_by_division(n);
      res.prime_value = n[31:0];
      return res;
    end
    if (n < 2) begin
      cand = 2;
    end else if (n == 2) begin
      cand = 3;
    end else if (n >= top_val) begin
      ovf = 1'b1;
    end else begin
      cand = n + 1;
      // advance to the first 6k+-1 candidate
      while (!ovf && cand % 6 != 1 && cand % 6 != 5) begin
        if (cand >= top_val) ovf = 1'b1;
        else cand++;
      end
      while (!ovf && !prime_by_division(cand)) begin
        step = (cand % 6 == 1) ? 4 : 2;
        if (top_val - cand < step) ovf = 1'b1;
        else cand += step;
      end
    end
    if (ovf) begin
      res.overflow = 1'b1;
    end else begin
      res.is_prime = 1'b1;
      res.prime_value = cand[31:0];
    end
    return res;
  endfunction

  // Call right after a rising edge; returns at the edge that accepts the transaction.
  task automatic present_number(input ptn_pkg::in_t item, input ptn_pkg::out_t expv);
    bit calm;
    calm = (offered_count >= 50 && offered_count < 75);
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    prime_results_q.push_back(expv);
    offered_count++;
  endtask

  initial begin
    ptn_pkg::in_t  item;
    ptn_pkg::out_t expv;
    int unsigned   pick;
    int unsigned   factor;
    directed_rows = '{
      {FUNC_TEST, 32'd0,          TYPED,   1'b0, 32'd0,          1'b0},
      {FUNC_TEST, 32'd1,          TYPED,   1'b0, 32'd1,          1'b0},
      {FUNC_TEST, 32'd2,          TYPED,   1'b1, 32'd2,          1'b0},
      {FUNC_TEST, 32'd3,          TYPED,   1'b1, 32'd3,          1'b0},
      {FUNC_TEST, 32'd4,          TYPED,   1'b0, 32'd4,          1'b0},
      {FUNC_TEST, 32'hFFFF_FFFF,  TYPED,   1'b0, 32'hFFFF_FFFF,  1'b0},
      {FUNC_TEST, 32'h8000_0000,  TYPED,   1'b0, 32'h8000_0000,  1'b0},
      {FUNC_NEXT, 32'd0,          TYPED,   1'b1, 32'd2,          1'b0},
      {FUNC_NEXT, 32'd1,          TYPED,   1'b1, 32'd2,          1'b0},
      {FUNC_NEXT, 32'd2,          TYPED,   1'b1, 32'd3,          1'b0},
      {FUNC_NEXT, 32'hFFFF_FFFF,  TYPED,   1'b0, 32'd0,          1'b1},
      {FUNC_NEXT, 32'hFFFF_FFFE,  TYPED,   1'b0, 32'd0,          1'b1},
      {FUNC_TEST, 32'd5,          PREDICT, 1'b0, 32'd0,          1'b0},
      {FUNC_TEST, 32'd25,         PREDICT, 1'b0, 32'd0,          1'b0},
      {FUNC_TEST, 32'd49,         PREDICT, 1'b0, 32'd0,          1'b0},
      {FUNC_TEST, 32'd35,         PREDICT, 1'b0, 32'd0,          1'b0},
      {FUNC_TEST, 32'd121,        PREDICT, 1'b0, 32'd0,          1'b0},
      {FUNC_TEST, 32'h5555_5555,  PREDICT, 1'b0, 32'd0,          1'b0},
      {FUNC_TEST, 32'hFFFF_FFFE,  PREDICT, 1'b0, 32'd0,          1'b0},
      {FUNC_TEST, 32'd1000003,    PREDICT, 1'b0, 32'd0,          1'b0},
      {FUNC_NEXT, 32'd3,          PREDICT, 1'b0, 32'd0,          1'b0},
      {FUNC_NEXT, 32'd4,          PREDICT, 1'b0, 32'd0,          1'b0},
      {FUNC_NEXT, 32'd7,          PREDICT, 1'b0, 32'd0,          1'b0},
      {FUNC_NEXT, 32'd23,         PREDICT, 1'b0, 32'd0,          1'b0},
      {FUNC_NEXT, 32'd1000000,    PREDICT, 1'b0, 32'd0,          1'b0}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      item.func   = directed_rows[i].func;
      item.number = directed_rows[i].number;
      if (directed_rows[i].typed) begin
        expv.is_prime    = directed_rows[i].is_prime;
        expv.prime_value = directed_rows[i].prime_value;
        expv.overflow    = directed_rows[i].overflow;
      end else begin
        expv = predict_result(item);
      end
      present_number(item, expv);
    end

    // Keep most operands small: a 32-bit prime needs trial division by every 6k+-1 divisor up to its square root.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      item.func = 1'($urandom_range(1));
      if (pick < 60) begin
        item.number = $urandom_range(4095);
      end else if (pick < 80) begin
        item.number = $urandom_range(32'h000F_FFFF);
      end else if (pick < 93) begin
        // full-width operand with a small factor keeps the test short
        item.func = FUNC_TEST;
        case ($urandom_range(3))
          0:       factor = 2;
          1:       factor = 3;
          2:       factor = 5;
          default: factor = 7;
        endcase
        item.number = $urandom_range(32'hFFFF_FFFF / factor) * factor;
      end else begin
        item.func = FUNC_NEXT;
        item.number = 32'hFFFF_FFFF - $urandom_range(1);
      end
      present_number(item, predict_result(item));
    end

    in_valid <= 1'b0;
    while (prime_results_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (prime_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: is_prime=%b prime_value=%0d overflow=%b",
                     out_data.is_prime, out_data.prime_value, out_data.overflow);
        end else begin
          want_result = prime_results_q.pop_front();
          if (out_data.is_prime !== want_result.is_prime ||
              out_data.prime_value !== want_result.prime_value ||
              out_data.overflow !== want_result.overflow) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: expected %b/%0d/%b, got %b/%0d/%b",
                       results_seen, want_result.is_prime, want_result.prime_value,
                       want_result.overflow, out_data.is_prime, out_data.prime_value,
                       out_data.overflow);
          end
        end
      end
      // hold off once for a long stretch so the next transaction backs up
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(results_seen >= 60 && results_seen < 85) && ($urandom_range(99) < 15);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule
